[design/rau_pkg.sv]
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int RES_W = 34;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_RED = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]               req_type;
        logic [OPERAND_WIDTH-1:0] a_num;
        logic [OPERAND_WIDTH-1:0] a_den;
        logic [OPERAND_WIDTH-1:0] b_num;
        logic [OPERAND_WIDTH-1:0] b_den;
    } rau_req_t;

    typedef struct packed {
        logic [RES_W-1:0] res_num;
        logic [RES_W-1:0] res_den;
        logic             was_reduced;
        logic             status;
    } res_word_t;

endpackage

[design/rational_arithmetic_unit_top.sv]
// Rational arithmetic unit: cross-multiply, Euclidean GCD, reduce.
// Depends on rau_pkg.
//
//  port group   dir  qualifier  content
//  start/req    in   start      rau_req_t (op, two fractions)
//  result       out  done       rau result word
//
// Datapath: the products are formed by a bit-serial shift-add multiplier, one bit per
// cycle over the operand width, then the raw sum is formed in S_SUM.
// Each Euclid modulo step and each final division runs on one shared restoring
// divider that retires one quotient bit per cycle.
// busy is high from accept until done. Reset clears all control state.
// The receiver cannot stall: done is a single-cycle strobe.
module rational_arithmetic_unit_top
    import rau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  rau_req_t  req,
    output logic      busy,
    output logic      done,
    output res_word_t result
);
    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2*W + 2;             // product / sum width
    localparam int AW = (PW > RES_W) ? PW : RES_W;
    localparam int CW = $clog2(AW + 2);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_SUM  = 8'b0000_0100,
        S_GCD  = 8'b0000_1000,
        S_MOD  = 8'b0001_0000,
        S_DVN  = 8'b0010_0000,
        S_DVD  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]    op_reg;
    logic [W-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic [PW-1:0] p0_reg, p1_reg, p2_reg;  // accumulators: a*x, b*y, den
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] num_reg, den_reg;
    logic          nneg_reg, dneg_reg;
    logic [AW-1:0] x_reg, y_reg;
    // divider
    logic [AW-1:0] dq_reg, drem_reg, ddiv_reg;
    logic          mod_x_reg;
    res_word_t     res_reg;
    logic          done_reg;

    // serial multiply: accumulate sign-extended multiplicands for three products at once
    logic [W-1:0]  m0, m1, m2;
    logic          bitv, last_bit;
    always_comb
    begin
        m0 = an_reg;
        m1 = bn_reg;
        m2 = ad_reg;
    end

    // Multiplier bits come from per-product shift registers, all at bit position cnt.
    logic [W-1:0] sh0_reg, sh1_reg, sh2_reg;
    logic [PW-1:0] ad0, ad1, ad2;
    always_comb
    begin
        last_bit = (cnt_reg == CW'(W-1));
        ad0 = sh0_reg[0] ? (PW'($signed(m0)) << cnt_reg) : '0;
        ad1 = sh1_reg[0] ? (PW'($signed(m1)) << cnt_reg) : '0;
        ad2 = sh2_reg[0] ? (PW'($signed(m2)) << cnt_reg) : '0;
        bitv = last_bit;
    end

    // raw results after multiply, sign-aware (top multiplier bit has negative weight)
    logic [PW-1:0] n_raw, d_raw;
    logic [AW-1:0] n_ext, d_ext;
    always_comb
    begin
        unique case (op_reg)
            OP_ADD:          n_raw = p0_reg + p1_reg;
            OP_SUB:          n_raw = p0_reg - p1_reg;
            OP_MUL, OP_DIV:  n_raw = p0_reg;
            default:         n_raw = PW'($signed(an_reg));
        endcase
        if (op_reg == OP_ADD || op_reg == OP_SUB || op_reg == OP_MUL || op_reg == OP_DIV)
            d_raw = p2_reg;
        else
            d_raw = PW'($signed(ad_reg));
        n_ext = AW'($signed(n_raw));
        d_ext = AW'($signed(d_raw));
    end

    // restoring divider step
    logic [AW:0]   trial;
    logic [AW-1:0] rem_sh;
    always_comb
    begin
        rem_sh = {drem_reg[AW-2:0], dq_reg[AW-1]};
        trial  = {1'b0, rem_sh} - {1'b0, ddiv_reg};
    end

    logic [RES_W-1:0] q_signed;
    always_comb
    begin
        q_signed = RES_W'(dq_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_MUL;
            S_MUL:  if (last_bit) state_next = S_SUM;
            S_SUM:  state_next = S_GCD;
            S_GCD:  if (x_reg == '0 || y_reg == '0) state_next = S_DVN;
                    else state_next = S_MOD;
            S_MOD:  if (cnt_reg == CW'(AW-1)) state_next = S_GCD;
            S_DVN:  if (cnt_reg == CW'(AW)) state_next = S_DVD;
            S_DVD:  if (cnt_reg == CW'(AW)) state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_OUT);
            unique case (state_reg)
                S_IDLE:  cnt_reg <= '0;
                S_MUL:   cnt_reg <= last_bit ? '0 : cnt_reg + 1'b1;
                S_GCD:   cnt_reg <= '0;
                S_MOD:   cnt_reg <= (cnt_reg == CW'(AW-1)) ? '0 : cnt_reg + 1'b1;
                S_DVN, S_DVD: cnt_reg <= (cnt_reg == CW'(AW)) ? '0 : cnt_reg + 1'b1;
                default: cnt_reg <= '0;
            endcase
        end
    end

    logic [AW-1:0] g_val;
    always_comb g_val = x_reg | y_reg;   // one of them is zero at end of Euclid

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg  <= req.req_type;
                an_reg  <= req.a_num;
                ad_reg  <= req.a_den;
                bn_reg  <= req.b_num;
                bd_reg  <= req.b_den;
                p0_reg  <= '0;
                p1_reg  <= '0;
                p2_reg  <= '0;
                sh0_reg <= (op_t'(req.req_type) == OP_MUL) ? req.b_num : req.b_den;
                sh1_reg <= req.a_den;
                sh2_reg <= (op_t'(req.req_type) == OP_DIV) ? req.b_num : req.b_den;
            end
            S_MUL:
            begin
                // top bit of the multiplier carries negative weight
                p0_reg  <= bitv ? p0_reg - ad0 : p0_reg + ad0;
                p1_reg  <= bitv ? p1_reg - ad1 : p1_reg + ad1;
                p2_reg  <= bitv ? p2_reg - ad2 : p2_reg + ad2;
                sh0_reg <= sh0_reg >> 1;
                sh1_reg <= sh1_reg >> 1;
                sh2_reg <= sh2_reg >> 1;
            end
            S_SUM:
            begin
                num_reg  <= n_ext;
                den_reg  <= d_ext;
                nneg_reg <= n_ext[AW-1];
                dneg_reg <= d_ext[AW-1];
                x_reg    <= n_ext[AW-1] ? AW'(-n_ext) : n_ext;
                y_reg    <= d_ext[AW-1] ? AW'(-d_ext) : d_ext;
            end
            S_GCD:
            begin
                // load divider: larger mod smaller, or the first final division
                drem_reg <= '0;
                if (x_reg != '0 && y_reg != '0)
                begin
                    mod_x_reg <= (y_reg <= x_reg);
                    dq_reg    <= (y_reg <= x_reg) ? x_reg : y_reg;
                    ddiv_reg  <= (y_reg <= x_reg) ? y_reg : x_reg;
                end
                else
                begin
                    dq_reg   <= nneg_reg ? AW'(-num_reg) : num_reg;
                    ddiv_reg <= g_val;
                end
            end
            S_MOD, S_DVN, S_DVD:
            begin
                if (state_reg != S_MOD && cnt_reg == CW'(AW))
                begin
                    if (state_reg == S_DVN)
                    begin
                        res_reg.res_num <= nneg_reg ? RES_W'(-dq_reg) : q_signed;
                        dq_reg   <= dneg_reg ? AW'(-den_reg) : den_reg;
                        drem_reg <= '0;
                    end
                    else
                        res_reg.res_den <= dneg_reg ? RES_W'(-dq_reg) : q_signed;
                end
                else
                begin
                    drem_reg <= trial[AW] ? rem_sh : trial[AW-1:0];
                    dq_reg   <= {dq_reg[AW-2:0], ~trial[AW]};
                    if (state_reg == S_MOD && cnt_reg == CW'(AW-1))
                    begin
                        if (mod_x_reg) x_reg <= trial[AW] ? rem_sh : trial[AW-1:0];
                        else           y_reg <= trial[AW] ? rem_sh : trial[AW-1:0];
                    end
                end
            end
            S_OUT:
            begin
                if (ddiv_reg == '0)
                begin
                    res_reg.res_num     <= '0;
                    res_reg.res_den     <= '0;
                    res_reg.was_reduced <= 1'b0;
                    res_reg.status      <= 1'b1;
                end
                else
                begin
                    res_reg.was_reduced <= (ddiv_reg != AW'(1));
                    res_reg.status      <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.status && result.was_reduced))
        else $error("status and was_reduced both set");
    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> done) else $error("done missing after output state");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");

endmodule
